// File: hdl/ptte_pkg.sv
`timescale 1ns / 1ps
package ptte_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int DIV_STEPS = 18;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [15:0] TICK_RESET = 16'd1092;

	localparam logic [1:0] ACT_CREATE = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [2:0] KIND_CREATED = 3'd0;
	localparam logic [2:0] KIND_FULL = 3'd1;
	localparam logic [2:0] KIND_ENTRY = 3'd2;
	localparam logic [2:0] KIND_EMPTY = 3'd3;
	localparam logic [2:0] KIND_CLEARED = 3'd4;

	localparam logic [23:0] POS_MAX = 24'h7FFFFF;
	localparam logic [23:0] POS_MIN = 24'h800000;

	typedef struct packed {
		logic [23:0] pos_x;
		logic [23:0] pos_y;
		logic [15:0] vel_x;
		logic [15:0] vel_y;
		logic [9:0] size;
		logic [31:0] born;
		logic [31:0] dies;
		logic [17:0] wd;
		logic vis;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_A,
		ST_UP_B,
		ST_UP_DIV,
		ST_UP_WR,
		ST_RM_RD,
		ST_RM_CHK,
		ST_RM_LRD,
		ST_RM_CPY,
		ST_EMPTY,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

endpackage

// File: hdl/particle_table_tick_engine_top.sv
`timescale 1ns / 1ps
// Particle table with create, clear and tick actions. Create and clear each return one
// word. A tick walks the table three times through one shared datapath: the update pass
// reads each live particle, finds overlap and multiplies, moves it, runs 18 steps of the
// restoring divider for the size ratio (none when it needs no division) and writes back;
// the removal pass copies the last particle over each expired one; the report pass sends
// one word per particle, held by any output stall. The registered read of the particle
// memory sets the pace of the removal and report passes. No input is taken during a tick.
module particle_table_tick_engine_top
	import ptte_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	// time_now, pos_x, pos_y, particle_size, expiry_tick, vel_x, vel_y,
	// area_x, area_y, area_w, area_h
	input logic [247:0] s_tdata,
	input logic [1:0] s_tuser, // action
	output logic m_tvalid,
	input logic m_tready,
	// slot, rect_x, rect_y, rect_w, rect_h, visible, zero pad
	output logic [95:0] m_tdata,
	output logic [2:0] m_tuser, // kind
	output logic m_tlast
);

	state_t state_q, state_nx;

	logic [15:0] tick_q;
	logic [CNT_W-1:0] live_q, n_q, i_q;
	logic [31:0] now_q;
	logic [23:0] ax_q, ay_q;
	logic [22:0] aw_q, ah_q;

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q, ent_q, wdata, ent_ld;
	logic we;
	logic [IDX_W-1:0] raddr, waddr;

	logic signed [32:0] prodx_q, prody_q;
	logic [49:0] prodn_q;
	logic [31:0] den_q, rem_q;
	logic [17:0] low_q, quo_q;
	logic [STEP_W-1:0] step_q;
	logic sc_zero_q, sc_full_q;

	logic m_valid_q, m_last_q;
	logic [2:0] m_kind_q;
	logic [5:0] m_slot_q;
	logic [23:0] m_x_q, m_y_q;
	logic [17:0] m_w_q, m_h_q;
	logic m_vis_q;

	logic s_acc, slot_free, full_tbl, m_load;
	logic [1:0] action;
	logic [17:0] full_sz, full_in;
	logic expire, vis_c;
	logic [32:0] trial;
	logic trial_ge;
	logic signed [25:0] px_e, py_e, ax_e, ay_e;
	logic signed [33:0] sum_x, sum_y;
	logic [23:0] new_x, new_y;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, tick_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			tick_q <= pwdata[15:0];
		end
	end

	assign action = s_tuser;
	assign s_acc = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;
	assign full_tbl = live_q >= CNT_W'(TABLE_DEPTH);
	assign full_in = {s_tdata[89:80], 8'd0};
	assign full_sz = {ent_q.size, 8'd0};
	assign expire = now_q >= rdata_q.dies;
	assign m_load = ((state_q == ST_IDLE) && s_acc
			&& (action == ACT_CREATE || action == ACT_CLEAR))
		|| ((state_q == ST_EMPTY || state_q == ST_OUT_LD) && slot_free);

	// overlap on the old rectangle, 26 bits so the sums cannot wrap
	always_comb begin
		px_e = 26'(signed'(rdata_q.pos_x));
		py_e = 26'(signed'(rdata_q.pos_y));
		ax_e = 26'(signed'(ax_q));
		ay_e = 26'(signed'(ay_q));
		vis_c = (ax_e < px_e + $signed({8'd0, rdata_q.wd}))
			&& (ax_e + $signed({3'd0, aw_q}) > px_e)
			&& (ay_e < py_e + $signed({8'd0, rdata_q.wd}))
			&& (ay_e + $signed({3'd0, ah_q}) > py_e);
	end

	always_comb begin
		ent_ld = rdata_q;
		ent_ld.vis = vis_c;
	end

	// floor shift of the velocity product, then saturate
	always_comb begin
		sum_x = 34'(signed'(ent_q.pos_x)) + 34'(prodx_q >>> 12);
		sum_y = 34'(signed'(ent_q.pos_y)) + 34'(prody_q >>> 12);
		if (sum_x > 34'(signed'(POS_MAX))) new_x = POS_MAX;
		else if (sum_x < 34'(signed'(POS_MIN))) new_x = POS_MIN;
		else new_x = sum_x[23:0];
		if (sum_y > 34'(signed'(POS_MAX))) new_y = POS_MAX;
		else if (sum_y < 34'(signed'(POS_MIN))) new_y = POS_MIN;
		else new_y = sum_y[23:0];
	end

	assign trial = {rem_q, low_q[17]} - {1'b0, den_q};
	assign trial_ge = {rem_q, low_q[17]} >= {1'b0, den_q};

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && action == ACT_TICK)
					state_nx = (live_q == '0) ? ST_EMPTY : ST_UP_RD;
			end
			ST_UP_RD: state_nx = ST_UP_A;
			ST_UP_A: state_nx = ST_UP_B;
			ST_UP_B: state_nx = (sc_zero_q || sc_full_q) ? ST_UP_WR : ST_UP_DIV;
			ST_UP_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1))
					state_nx = ST_UP_WR;
			end
			ST_UP_WR: state_nx = (i_q + 1'b1 == n_q) ? ST_RM_RD : ST_UP_RD;
			ST_RM_RD: begin
				if (i_q >= n_q)
					state_nx = (n_q == '0) ? ST_EMPTY : ST_OUT_RD;
				else
					state_nx = ST_RM_CHK;
			end
			ST_RM_CHK: state_nx = expire ? ST_RM_LRD : ST_RM_RD;
			ST_RM_LRD: state_nx = ST_RM_CPY;
			ST_RM_CPY: state_nx = ST_RM_RD;
			ST_EMPTY: begin
				if (slot_free)
					state_nx = ST_IDLE;
			end
			ST_OUT_RD: state_nx = (i_q >= n_q) ? ST_IDLE : ST_OUT_LD;
			ST_OUT_LD: begin
				if (slot_free)
					state_nx = ST_OUT_RD;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		we = 1'b0;
		waddr = i_q[IDX_W-1:0];
		raddr = i_q[IDX_W-1:0];
		wdata = ent_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = slot_free;
				waddr = live_q[IDX_W-1:0];
				we = s_acc && action == ACT_CREATE && !full_tbl;
				wdata.pos_x = s_tdata[55:32];
				wdata.pos_y = s_tdata[79:56];
				wdata.size = s_tdata[89:80];
				wdata.dies = s_tdata[121:90];
				wdata.vel_x = s_tdata[137:122];
				wdata.vel_y = s_tdata[153:138];
				wdata.born = s_tdata[31:0];
				wdata.wd = full_in;
				wdata.vis = 1'b0;
			end
			ST_UP_WR: begin
				we = 1'b1;
				wdata.wd = sc_zero_q ? 18'd0 : (sc_full_q ? full_sz : quo_q);
			end
			ST_RM_LRD: raddr = IDX_W'(n_q - 1'b1);
			ST_RM_CPY: begin
				we = 1'b1;
				wdata = rdata_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			live_q <= '0;
			n_q <= '0;
			i_q <= '0;
			step_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			m_valid_q <= m_load || (m_valid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					n_q <= live_q;
					if (s_acc && action == ACT_CREATE && !full_tbl)
						live_q <= live_q + 1'b1;
					if (s_acc && action == ACT_CLEAR)
						live_q <= '0;
				end
				ST_UP_B: step_q <= '0;
				ST_UP_DIV: step_q <= step_q + 1'b1;
				ST_UP_WR: i_q <= (i_q + 1'b1 == n_q) ? '0 : i_q + 1'b1;
				ST_RM_RD: begin
					if (i_q >= n_q) begin
						live_q <= n_q;
						i_q <= '0;
					end
				end
				ST_RM_CHK: begin
					if (!expire)
						i_q <= i_q + 1'b1;
				end
				ST_RM_CPY: n_q <= n_q - 1'b1;
				ST_OUT_LD: begin
					if (slot_free)
						i_q <= i_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath and output word, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				now_q <= s_tdata[31:0];
				ax_q <= s_tdata[177:154];
				ay_q <= s_tdata[201:178];
				aw_q <= s_tdata[224:202];
				ah_q <= s_tdata[247:225];
				if (s_acc) begin
					m_last_q <= 1'b1;
					m_vis_q <= 1'b0;
					if (action == ACT_CREATE && !full_tbl) begin
						m_kind_q <= KIND_CREATED;
						m_slot_q <= 6'(live_q);
						m_x_q <= s_tdata[55:32];
						m_y_q <= s_tdata[79:56];
						m_w_q <= full_in;
						m_h_q <= full_in;
					end else begin
						m_kind_q <= (action == ACT_CLEAR) ? KIND_CLEARED : KIND_FULL;
						m_slot_q <= '0;
						m_x_q <= '0;
						m_y_q <= '0;
						m_w_q <= '0;
						m_h_q <= '0;
					end
				end
			end
			ST_UP_A: begin
				ent_q <= ent_ld;
				prodx_q <= $signed(rdata_q.vel_x) * $signed({1'b0, tick_q});
				prody_q <= $signed(rdata_q.vel_y) * $signed({1'b0, tick_q});
				prodn_q <= {rdata_q.size, 8'd0} * (rdata_q.dies - now_q);
				den_q <= rdata_q.dies - rdata_q.born;
				sc_zero_q <= (rdata_q.dies <= rdata_q.born) || (rdata_q.dies <= now_q);
				sc_full_q <= now_q <= rdata_q.born;
			end
			ST_UP_B: begin
				ent_q.pos_x <= new_x;
				ent_q.pos_y <= new_y;
				// quotient fits 18 bits, so the upper part is already below den
				rem_q <= prodn_q[49:18];
				low_q <= prodn_q[17:0];
			end
			ST_UP_DIV: begin
				rem_q <= trial_ge ? trial[31:0] : {rem_q[30:0], low_q[17]};
				low_q <= {low_q[16:0], 1'b0};
				quo_q <= {quo_q[16:0], trial_ge};
			end
			ST_EMPTY: begin
				if (slot_free) begin
					m_kind_q <= KIND_EMPTY;
					m_last_q <= 1'b1;
					m_vis_q <= 1'b0;
					m_slot_q <= '0;
					m_x_q <= '0;
					m_y_q <= '0;
					m_w_q <= '0;
					m_h_q <= '0;
				end
			end
			ST_OUT_LD: begin
				if (slot_free) begin
					m_kind_q <= KIND_ENTRY;
					m_last_q <= i_q + 1'b1 == n_q;
					m_vis_q <= rdata_q.vis;
					m_slot_q <= 6'(i_q);
					m_x_q <= rdata_q.pos_x;
					m_y_q <= rdata_q.pos_y;
					m_w_q <= rdata_q.wd;
					m_h_q <= rdata_q.wd;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser = m_kind_q;
	assign m_tlast = m_last_q;
	assign m_tdata = {5'd0, m_vis_q, m_h_q, m_w_q, m_y_q, m_x_q, m_slot_q};

endmodule
